// ===== rtl/lzssd_pkg.sv =====
package lzssd_pkg;

  localparam int OFFSET_BITS = 12;
  localparam int LENGTH_BITS = 4;
  localparam int BYTE_W      = 8;
  localparam int SIZE_W      = 25;
  localparam int WIN_DEPTH   = 1 << OFFSET_BITS;
  localparam int TOKEN_W     = 1 + OFFSET_BITS + LENGTH_BITS;
  localparam int TBITS_W     = $clog2(TOKEN_W + 1);
  localparam int LIT_BITS    = 1 + BYTE_W;
  localparam int END_BITS    = 1 + OFFSET_BITS;
  localparam int LEN_W       = LENGTH_BITS + 1;
  localparam int MIN_MATCH   = 2;
  localparam int REM_W       = $clog2(BYTE_W + 1);
  localparam int DATA_W      = 32;
  localparam int PADDR_W     = 3;
  localparam int REG_REAL_SIZE = 0;

  typedef struct packed {
    logic accept;
    logic do_bit;
    logic copy_rd;
    logic copy_wr;
    logic pad_push;
    logic flush;
  } lzssd_cmd_t;

  typedef struct packed {
    logic finished;
    logic bits_done;
    logic tok_copy;
    logic copy_more;
    logic can_push;
    logic pad_needed;
    logic pend_valid;
    logic out_free;
  } lzssd_sts_t;

endpackage

// ===== rtl/lzss_stream_decompressor_unit.sv =====
// channel   signals                                                        direction
// input     in_valid in_ready in_byte start_stream                         in
// output    out_valid out_ready out_byte is_padding last_of_run stream_done  out
// config    psel penable pwrite paddr pwdata prdata pready                 in/out
//
// a packed byte passes through accept, the bit state for each of its bits, a copy read and a copy write
// per copied byte, the padding state for each padding byte, and a flush
// a copy yields up to 17 bytes, and a stream end adds up to 3 padding bytes
// rst is synchronous, clears control state; the window needs no clearing pass
// because a fill mark tracks which window entries were written since start
// output stalls hold the engine once the pending and output registers are full
module lzss_stream_decompressor_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [lzssd_pkg::BYTE_W-1:0]         in_byte,
  input  logic                                 start_stream,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [lzssd_pkg::BYTE_W-1:0]         out_byte,
  output logic                                 is_padding,
  output logic                                 last_of_run,
  output logic                                 stream_done,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lzssd_pkg::PADDR_W-1:0]        paddr,
  input  logic [lzssd_pkg::DATA_W-1:0]         pwdata,
  output logic [lzssd_pkg::DATA_W-1:0]         prdata,
  output logic                                 pready
);

  lzssd_pkg::lzssd_cmd_t             cmd;
  lzssd_pkg::lzssd_sts_t             sts;
  logic                              cfg_we;
  logic                              reg_sel;
  logic [lzssd_pkg::SIZE_W-1:0]      real_size;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[lzssd_pkg::PADDR_W-1:2] ==
                    (lzssd_pkg::PADDR_W-2)'(lzssd_pkg::REG_REAL_SIZE));
  assign cfg_we  = psel && penable && pwrite && reg_sel;
  assign prdata  = reg_sel ? lzssd_pkg::DATA_W'(real_size) : '0;

  lzssd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzssd_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_byte      (in_byte),
    .start_stream (start_stream),
    .cfg_we       (cfg_we),
    .cfg_wdata    (pwdata[lzssd_pkg::SIZE_W-1:0]),
    .real_size    (real_size),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .is_padding   (is_padding),
    .last_of_run  (last_of_run),
    .stream_done  (stream_done)
  );

endmodule

// ===== rtl/lzssd_ctrl.sv =====
module lzssd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lzssd_pkg::lzssd_sts_t sts,
  output lzssd_pkg::lzssd_cmd_t cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_BIT     = 3'd1;
  localparam logic [2:0] S_COPY_RD = 3'd2;
  localparam logic [2:0] S_COPY_WR = 3'd3;
  localparam logic [2:0] S_PAD     = 3'd4;
  localparam logic [2:0] S_FLUSH   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_BIT;
        end
      end
      S_BIT: begin
        if (sts.finished || sts.bits_done) begin
          state_next = S_PAD;
        end else if (sts.can_push) begin
          cmd.do_bit = 1'b1;
          if (sts.tok_copy) begin
            state_next = S_COPY_RD;
          end
        end
      end
      S_COPY_RD: begin
        if (sts.finished || !sts.copy_more) begin
          state_next = S_BIT;
        end else begin
          cmd.copy_rd = 1'b1;
          state_next  = S_COPY_WR;
        end
      end
      S_COPY_WR: begin
        if (sts.can_push) begin
          cmd.copy_wr = 1'b1;
          state_next  = S_COPY_RD;
        end
      end
      S_PAD: begin
        if (sts.pad_needed) begin
          if (sts.can_push) begin
            cmd.pad_push = 1'b1;
          end
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_copy_wr_follows_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.copy_rd |=> state == S_COPY_WR)
    else $error("copy read not followed by copy write state");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state == S_BIT && !in_ready)
    else $error("accept did not start bit processing");

endmodule

// ===== rtl/lzssd_datapath.sv =====
module lzssd_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lzssd_pkg::lzssd_cmd_t                cmd,
  output lzssd_pkg::lzssd_sts_t                sts,
  input  logic [lzssd_pkg::BYTE_W-1:0]         in_byte,
  input  logic                                 start_stream,
  input  logic                                 cfg_we,
  input  logic [lzssd_pkg::SIZE_W-1:0]         cfg_wdata,
  output logic [lzssd_pkg::SIZE_W-1:0]         real_size,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [lzssd_pkg::BYTE_W-1:0]         out_byte,
  output logic                                 is_padding,
  output logic                                 last_of_run,
  output logic                                 stream_done
);

  localparam int TW = lzssd_pkg::TOKEN_W;
  localparam int OB = lzssd_pkg::OFFSET_BITS;
  localparam int LB = lzssd_pkg::LENGTH_BITS;
  localparam int BW = lzssd_pkg::BYTE_W;

  logic [BW-1:0]                    win_mem [lzssd_pkg::WIN_DEPTH];
  logic [BW-1:0]                    rdata;
  logic                             rd_ok;

  logic [BW-1:0]                    byte_sr;
  logic [lzssd_pkg::REM_W-1:0]      rem;
  logic [TW-1:0]                    partial;
  logic [lzssd_pkg::TBITS_W-1:0]    pbits;
  logic [OB-1:0]                    wp;
  logic                             full;
  logic [lzssd_pkg::SIZE_W-1:0]     emitted;
  logic                             finished;
  logic                             was_finished;
  logic [OB-1:0]                    cpos;
  logic [lzssd_pkg::LEN_W-1:0]      clen;
  logic [lzssd_pkg::LEN_W-1:0]      ccnt;
  logic [1:0]                       pad_count;

  logic                             pend_valid;
  logic [BW-1:0]                    pend_byte;
  logic                             pend_pad;

  logic [TW-1:0]                    new_partial;
  logic [lzssd_pkg::TBITS_W-1:0]    nb;
  logic                             flag;
  logic                             tok_lit;
  logic                             tok_end;
  logic                             tok_copy;
  logic                             emit;
  logic [BW-1:0]                    emit_val;
  logic                             push;
  logic [BW-1:0]                    push_val;
  logic [lzssd_pkg::SIZE_W-1:0]     emitted_inc;
  logic [OB-1:0]                    rd_addr;
  logic                             rd_valid_pos;
  logic                             out_free;

  assign new_partial = {partial[TW-2:0], byte_sr[BW-1]};
  assign nb          = pbits + 1'b1;
  assign flag        = new_partial[pbits];
  assign tok_lit     = flag && (nb == lzssd_pkg::TBITS_W'(lzssd_pkg::LIT_BITS));
  assign tok_end     = !flag && (nb == lzssd_pkg::TBITS_W'(lzssd_pkg::END_BITS))
                       && (new_partial[OB-1:0] == '0);
  assign tok_copy    = !flag && (nb == lzssd_pkg::TBITS_W'(TW));

  assign emit     = (cmd.do_bit && tok_lit) || cmd.copy_wr;
  assign emit_val = cmd.copy_wr ? (rd_ok ? rdata : '0) : new_partial[BW-1:0];
  assign push     = emit || cmd.pad_push;
  assign push_val = cmd.pad_push ? '0 : emit_val;

  assign emitted_inc = emitted + 1'b1;
  assign rd_addr     = cpos + OB'(ccnt);
  assign rd_valid_pos = full || ((rd_addr != '0) && ((wp == '0) || (rd_addr < wp)));
  assign out_free    = !out_valid || out_ready;

  assign sts.finished   = finished;
  assign sts.bits_done  = (rem == '0);
  assign sts.tok_copy   = tok_copy;
  assign sts.copy_more  = (ccnt < clen);
  assign sts.can_push   = !pend_valid || out_free;
  assign sts.pad_needed = finished && !was_finished && ((emitted[1:0] + pad_count) != 2'd0);
  assign sts.pend_valid = pend_valid;
  assign sts.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (emit) begin
      win_mem[wp] <= emit_val;
    end
    if (cmd.copy_rd) begin
      rdata <= win_mem[rd_addr];
      rd_ok <= rd_valid_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      real_size <= lzssd_pkg::SIZE_W'(1);
    end else if (cfg_we) begin
      real_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem          <= '0;
      partial      <= '0;
      pbits        <= '0;
      wp           <= OB'(1);
      full         <= 1'b0;
      emitted      <= '0;
      finished     <= 1'b0;
      was_finished <= 1'b0;
      clen         <= '0;
      ccnt         <= '0;
      pad_count    <= '0;
    end else begin
      if (cmd.accept) begin
        byte_sr   <= in_byte;
        rem       <= lzssd_pkg::REM_W'(BW);
        pad_count <= '0;
        if (start_stream) begin
          partial      <= '0;
          pbits        <= '0;
          wp           <= OB'(1);
          full         <= 1'b0;
          emitted      <= '0;
          finished     <= 1'b0;
          was_finished <= 1'b0;
        end else begin
          was_finished <= finished;
        end
      end
      if (cmd.do_bit) begin
        byte_sr <= {byte_sr[BW-2:0], 1'b0};
        rem     <= rem - 1'b1;
        if (tok_lit || tok_end || tok_copy) begin
          partial <= '0;
          pbits   <= '0;
        end else begin
          partial <= new_partial;
          pbits   <= nb;
        end
        if (tok_end) begin
          finished <= 1'b1;
        end
        if (tok_copy) begin
          cpos <= new_partial[TW-2:LB];
          clen <= lzssd_pkg::LEN_W'(new_partial[LB-1:0]) +
                  lzssd_pkg::LEN_W'(lzssd_pkg::MIN_MATCH);
          ccnt <= '0;
        end
      end
      if (cmd.copy_wr) begin
        ccnt <= ccnt + 1'b1;
      end
      if (emit) begin
        wp       <= wp + 1'b1;
        full     <= full || (wp == '0);
        emitted  <= emitted_inc;
        finished <= (emitted_inc >= real_size);
      end
      if (cmd.pad_push) begin
        pad_count <= pad_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (push) begin
        pend_valid <= 1'b1;
        pend_byte  <= push_val;
        pend_pad   <= cmd.pad_push;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
      if ((push && pend_valid) || cmd.flush) begin
        out_valid   <= 1'b1;
        out_byte    <= pend_byte;
        is_padding  <= pend_pad;
        last_of_run <= cmd.flush;
        stream_done <= cmd.flush && finished && !was_finished;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ((push && pend_valid) || cmd.flush) |-> out_free)
    else $error("output register loaded while still holding a result");

  a_frozen_when_done: assert property (@(posedge clk) disable iff (rst)
    (finished && !cmd.accept) |=> emitted == $past(emitted))
    else $error("bytes emitted after stream end");

  a_token_bits: assert property (@(posedge clk) disable iff (rst)
    pbits < lzssd_pkg::TBITS_W'(TW))
    else $error("token bit count out of range");

  a_copy_bound: assert property (@(posedge clk) disable iff (rst)
    ccnt <= clen)
    else $error("copy ran past its length");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int BYTE_W       = lzssd_pkg::BYTE_W;
  localparam int OFFSET_BITS  = lzssd_pkg::OFFSET_BITS;
  localparam int LENGTH_BITS  = lzssd_pkg::LENGTH_BITS;
  localparam int SIZE_W       = lzssd_pkg::SIZE_W;
  localparam int DATA_W       = lzssd_pkg::DATA_W;
  localparam int WIN_DEPTH    = lzssd_pkg::WIN_DEPTH;
  localparam int TOKEN_W      = lzssd_pkg::TOKEN_W;
  localparam int LIT_BITS     = lzssd_pkg::LIT_BITS;
  localparam int END_BITS     = lzssd_pkg::END_BITS;
  localparam int MIN_MATCH    = lzssd_pkg::MIN_MATCH;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 300;
  localparam int REG_NONE     = 1;
  localparam int AW           = lzssd_pkg::PADDR_W;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_t;
  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              pad;
    logic              last;
    logic              done;
  } byte_rec_t;

  typedef struct {
    bit          typed;
    int          n;
    logic [31:0] bytes;
    logic [3:0]  pad;
    bit          done;
  } check_t;

  typedef struct {
    row_kind_t         kind;
    logic [BYTE_W-1:0] b;
    logic              s;
    int                reg_idx;
    logic [31:0]       val;
    check_t            chk;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [BYTE_W-1:0]  in_byte = '0;
  logic               start_stream = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [BYTE_W-1:0]  out_byte;
  logic               is_padding;
  logic               last_of_run;
  logic               stream_done;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [AW-1:0]      paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  lzss_stream_decompressor_unit dut (.*);

  always #4 clk = ~clk;

  // decoder shadow state
  logic [BYTE_W-1:0]  hist [WIN_DEPTH];
  logic [OFFSET_BITS-1:0] wr_pos;
  logic [SIZE_W-1:0]  emitted;
  logic [SIZE_W-1:0]  size_reg;
  logic [TOKEN_W-1:0] tok;
  int                 tok_bits;
  bit                 done_flag;
  byte_rec_t          run_bytes[$];

  byte_rec_t          expected_bytes[$];
  check_t             row_checks[$];
  check_t             no_check;
  int                 err_cnt = 0;
  int                 item_cnt = 0;
  int                 burst_left = 0;
  int                 holds_wanted = 0;
  int                 holds_done = 0;
  int                 hold_left = 0;
  int                 rx_cyc = 0;
  rx_mode_t           rx_mode = RX_ALWAYS;
  stim_row_t          dir_tab [26];

  function automatic void clear_stream();
    for (int i = 0; i < WIN_DEPTH; i++) hist[i] = '0;
    wr_pos = 1;
    emitted = '0;
    tok = '0;
    tok_bits = 0;
    done_flag = 0;
  endfunction

  function automatic void emit_byte(input logic [BYTE_W-1:0] v);
    run_bytes.push_back('{v, 1'b0, 1'b0, 1'b0});
    hist[wr_pos] = v;
    wr_pos = wr_pos + 1'b1;
    emitted = emitted + 1'b1;
    if (emitted >= size_reg) done_flag = 1;
  endfunction

  function automatic void decode_packed_byte(input logic [BYTE_W-1:0] b, input logic s);
    bit was_done;
    int len;
    int pad_n;
    logic [OFFSET_BITS-1:0] pos;
    run_bytes.delete();
    if (s) clear_stream();
    was_done = done_flag;
    for (int bi = BYTE_W - 1; bi >= 0 && !done_flag; bi--) begin
      tok = {tok[TOKEN_W-2:0], b[bi]};
      tok_bits++;
      if (tok[tok_bits-1]) begin
        if (tok_bits == LIT_BITS) begin
          emit_byte(tok[BYTE_W-1:0]);
          tok = '0;
          tok_bits = 0;
        end
      end else if (tok_bits == END_BITS) begin
        if (tok[OFFSET_BITS-1:0] == '0) begin
          done_flag = 1;
          tok = '0;
          tok_bits = 0;
        end
      end else if (tok_bits == TOKEN_W) begin
        pos = tok[LENGTH_BITS +: OFFSET_BITS];
        len = int'(tok[LENGTH_BITS-1:0]) + MIN_MATCH;
        tok = '0;
        tok_bits = 0;
        for (int c = 0; c < len && !done_flag; c++)
          emit_byte(hist[OFFSET_BITS'(pos + c)]);
      end
    end
    if (done_flag && !was_done) begin
      pad_n = (4 - int'(emitted[1:0])) % 4;
      repeat (pad_n) run_bytes.push_back('{8'h00, 1'b1, 1'b0, 1'b0});
      if (run_bytes.size() > 0) run_bytes[run_bytes.size()-1].done = 1'b1;
    end
    if (run_bytes.size() > 0) run_bytes[run_bytes.size()-1].last = 1'b1;
  endfunction

  function automatic stim_row_t row_pred(input logic [7:0] b, input logic s);
    stim_row_t r;
    r.kind = ROW_BYTE;
    r.b = b;
    r.s = s;
    r.chk.typed = 0;
    return r;
  endfunction

  function automatic stim_row_t row_typed(input logic [7:0] b, input logic s, input int n,
                                          input logic [31:0] bytes, input logic [3:0] pad,
                                          input bit done);
    stim_row_t r;
    r = row_pred(b, s);
    r.chk = '{1, n, bytes, pad, done};
    return r;
  endfunction

  function automatic stim_row_t row_cfg(input int idx, input logic [31:0] v);
    stim_row_t r;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.val = v;
    return r;
  endfunction

  function automatic logic [31:0] pick_size();
    logic [SIZE_W-1:0] v;
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) v = 25'h1000000;
    else if (r < 6) v = SIZE_W'($urandom_range(1, 40));
    else if (r == 6) v = '0;
    else if (r == 7) v = 25'h1FFFFFF;
    else v = SIZE_W'($urandom_range(41, 4000));
    return {7'($urandom), v};
  endfunction

  // accepted transactions on both channels
  always @(posedge clk) begin : mon
    byte_rec_t got;
    byte_rec_t want;
    check_t chk;
    if (!rst && in_valid && in_ready) begin
      chk = row_checks.pop_front();
      item_cnt++;
      decode_packed_byte(in_byte, start_stream);
      if (chk.typed) begin
        for (int k = 0; k < chk.n; k++)
          expected_bytes.push_back('{chk.bytes[31-8*k -: 8], chk.pad[3-k],
                                     k == chk.n - 1, chk.done && (k == chk.n - 1)});
      end else begin
        foreach (run_bytes[k]) expected_bytes.push_back(run_bytes[k]);
      end
    end
    if (!rst && out_valid && out_ready) begin
      got = '{out_byte, is_padding, last_of_run, stream_done};
      if (expected_bytes.size() == 0) begin
        if (err_cnt < 10)
          $display("unexpected output transaction: byte %h pad %b last %b done %b",
                   out_byte, is_padding, last_of_run, stream_done);
        err_cnt++;
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want) begin
          if (err_cnt < 10)
            $display("mismatch: exp byte %h pad %b last %b done %b, got byte %h pad %b last %b done %b",
                     want.data, want.pad, want.last, want.done,
                     got.data, got.pad, got.last, got.done);
          err_cnt++;
        end
      end
    end
  end

  // receiver stall pattern, with long hold-offs on request
  always @(posedge clk) begin
    rx_cyc++;
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (holds_done != holds_wanted) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (rx_cyc % 100 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_ALWAYS:   out_ready <= 1'b1;
        RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
        RX_MOSTLY:   out_ready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: out_ready <= ((rx_cyc % 7) < 2);
        default:     out_ready <= 1'b1;
      endcase
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic s, input check_t chk);
    row_checks.push_back(chk);
    in_valid <= 1'b1;
    in_byte <= b;
    start_stream <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      in_byte <= 8'($urandom);
      start_stream <= 1'($urandom);
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input int idx, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AW'(idx * 4);
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == lzssd_pkg::REG_REAL_SIZE) begin
      size_reg = v[SIZE_W-1:0];
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      if (prdata[SIZE_W-1:0] !== size_reg) begin
        if (err_cnt < 10)
          $display("real_size readback: exp %h, got %h", size_reg, prdata[SIZE_W-1:0]);
        err_cnt++;
      end
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6))
      push_byte(8'($urandom), ($urandom_range(0, 3) == 0), no_check);
  endtask

  task automatic send_stream();
    bit bits_q[$];
    int produced;
    int cfg_at;
    int lim;
    logic [7:0] lit;
    logic [7:0] b;
    logic [OFFSET_BITS-1:0] pos;
    logic [OFFSET_BITS-1:0] wp;
    logic [LENGTH_BITS-1:0] lf;
    produced = 0;
    repeat ($urandom_range(1, 24)) begin
      if ($urandom_range(0, 9) < 6) begin
        if ($urandom_range(0, 7) == 0) lit = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else lit = 8'($urandom);
        bits_q.push_back(1'b1);
        for (int i = 7; i >= 0; i--) bits_q.push_back(lit[i]);
        produced++;
      end else begin
        wp = OFFSET_BITS'(1 + produced);
        lim = (produced < 24) ? produced : 24;
        if (produced > 0 && $urandom_range(0, 3) != 0)
          pos = wp - OFFSET_BITS'($urandom_range(1, lim));
        else
          pos = OFFSET_BITS'($urandom_range(1, WIN_DEPTH - 1));
        if (pos == '0) pos = 1;
        lf = ($urandom_range(0, 2) == 0) ? '1 : LENGTH_BITS'($urandom);
        bits_q.push_back(1'b0);
        for (int i = OFFSET_BITS - 1; i >= 0; i--) bits_q.push_back(pos[i]);
        for (int i = LENGTH_BITS - 1; i >= 0; i--) bits_q.push_back(lf[i]);
        produced += int'(lf) + MIN_MATCH;
      end
    end
    // end token most of the time, else the stream is cut short
    if ($urandom_range(0, 9) < 7) repeat (END_BITS) bits_q.push_back(1'b0);
    while (bits_q.size() % 8 != 0) bits_q.push_back(1'($urandom));
    cfg_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, bits_q.size() / 8) : -1;
    for (int j = 0; j < bits_q.size() / 8; j++) begin
      if (j == cfg_at) begin
        wait_idle();
        reg_write(lzssd_pkg::REG_REAL_SIZE, pick_size());
      end
      for (int i = 0; i < 8; i++) b[7-i] = bits_q[8*j + i];
      push_byte(b, (j == 0), no_check);
    end
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[lzss_stream_decompressor_unit] ERROR");
    $finish;
  end

  initial begin
    int r;
    bit held_a;
    bit held_b;
    held_a = 0;
    held_b = 0;
    dir_tab = '{
      row_typed(8'hFF, 1, 0, 32'h0, 4'b0000, 0),
      row_typed(8'h80, 0, 4, 32'hFF000000, 4'b0111, 1),
      row_typed(8'hAA, 0, 0, 32'h0, 4'b0000, 0),
      row_cfg(lzssd_pkg::REG_REAL_SIZE, 32'h01000000),
      row_pred(8'h80, 1),
      row_typed(8'h7F, 0, 1, 32'h0, 4'b0000, 0),
      row_pred(8'hC0, 0),
      row_pred(8'h03, 0),
      row_pred(8'hE0, 0),
      row_typed(8'h00, 0, 1, 32'h0, 4'b1000, 1),
      row_cfg(REG_NONE, 32'h0),
      row_typed(8'hAD, 1, 0, 32'h0, 4'b0000, 0),
      row_typed(8'h00, 0, 1, 32'h5A000000, 4'b0000, 0),
      row_typed(8'h00, 1, 0, 32'h0, 4'b0000, 0),
      row_typed(8'h00, 0, 0, 32'h0, 4'b0000, 0),
      row_typed(8'hFF, 0, 0, 32'h0, 4'b0000, 0),
      row_cfg(lzssd_pkg::REG_REAL_SIZE, 32'h0),
      row_typed(8'hAD, 1, 0, 32'h0, 4'b0000, 0),
      row_typed(8'h00, 0, 4, 32'h5A000000, 4'b0111, 1),
      row_cfg(lzssd_pkg::REG_REAL_SIZE, 32'd5),
      row_pred(8'hA0, 1),
      row_pred(8'hD0, 0),
      row_pred(8'h80, 0),
      row_pred(8'h03, 0),
      row_pred(8'hFF, 0),
      row_cfg(lzssd_pkg::REG_REAL_SIZE, 32'd1)
    };
    size_reg = 1;
    clear_stream();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        wait_idle();
        reg_write(dir_tab[i].reg_idx, dir_tab[i].val);
      end else begin
        push_byte(dir_tab[i].b, dir_tab[i].s, dir_tab[i].chk);
      end
    end

    while (item_cnt < 400) begin
      if (!held_a && item_cnt > 120) begin
        holds_wanted++;
        held_a = 1;
      end
      if (!held_b && item_cnt > 320) begin
        holds_wanted++;
        held_b = 1;
      end
      r = $urandom_range(0, 9);
      if (r < 3) begin
        wait_idle();
        reg_write(lzssd_pkg::REG_REAL_SIZE, pick_size());
      end else if (r == 9) begin
        wait_idle();
        reg_write(REG_NONE, $urandom);
      end
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_stream();
    end

    wait_idle();
    if (expected_bytes.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("[lzss_stream_decompressor_unit] OK");
    end else begin
      $display("[lzss_stream_decompressor_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lzssd_pkg.sv
rtl/lzssd_ctrl.sv
rtl/lzssd_datapath.sv
rtl/lzss_stream_decompressor_unit.sv
test/testbench.sv
